// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants for the two-motor speed ramp and h-bridge duty
// block: item formats, register map, op codes and inter-stage records.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int NUM_MOTORS = 2;
  localparam int MOTOR_W    = 2;
  localparam int MIDX_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  // motors that own a bit of invert_mask
  localparam int INV_W      = 2;
  localparam int FULL_Q     = 32767;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd4;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_STOP = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [MOTOR_W-1:0]  motor;
    logic signed [15:0]  speed_cmd;
  } in_t;

  typedef struct packed {
    logic [MOTOR_W-1:0]  motor_index;
    logic [15:0]         fwd_duty;
    logic [15:0]         rev_duty;
    logic signed [15:0]  speed_now;
    logic                status;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [14:0] ramp_step;
    logic [14:0] max_speed;
    logic [15:0] duty_full_scale;
    logic        brake_mode;
    logic [INV_W-1:0] invert_mask;
  } cfg_t;

  // one per-motor step leaving the issue stage
  typedef struct packed {
    logic [MOTOR_W-1:0]  motor_index;
    op_e                 op;
    logic                pos;
    logic                neg;
    logic [14:0]         mag;
    logic signed [15:0]  speed_now;
    logic                status;
    logic                last;
  } step_t;

  // same step after the duty multiply
  typedef struct packed {
    logic [MOTOR_W-1:0]  motor_index;
    op_e                 op;
    logic                pos;
    logic                neg;
    logic [PROD_W-1:0]   prod;
    logic signed [15:0]  speed_now;
    logic                status;
    logic                last;
  } prod_t;

endpackage

// ===== rtl/msr_issue.sv =====
// ----------------------------------------------------------------------------
// msr_issue
// Input register and per-motor sequencer. Holds target and current speeds,
// applies set, ramp and clamp, stop and read; tick and stop step each motor.
// ----------------------------------------------------------------------------
module msr_issue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  msr_pkg::in_t   in_data,
  input  msr_pkg::cfg_t  cfg,
  output logic           step_valid,
  input  logic           step_ready,
  output msr_pkg::step_t step
);

  logic                        a_valid_r;
  msr_pkg::in_t                a_item_r;
  logic [msr_pkg::MIDX_W-1:0]  idx_r;
  logic signed [15:0]          tgt_r [msr_pkg::NUM_MOTORS];
  logic signed [15:0]          cur_r [msr_pkg::NUM_MOTORS];

  logic                        multi;
  logic [msr_pkg::MOTOR_W-1:0] m_sel;
  logic [msr_pkg::MIDX_W-1:0]  m_idx;
  logic                        motor_ok;
  logic                        inv;
  logic                        last_step;
  logic                        go;
  logic signed [15:0]          cur_sel;
  logic signed [15:0]          tgt_sel;
  logic signed [17:0]          cur18;
  logic signed [17:0]          tgt18;
  logic signed [17:0]          diff;
  logic signed [17:0]          step18;
  logic signed [17:0]          lim18;
  logic signed [17:0]          ramp;
  logic signed [15:0]          cur_new;
  logic signed [15:0]          cmd_sat;
  logic signed [15:0]          spd_user;

  always_comb begin
    multi     = (a_item_r.op == msr_pkg::OP_TICK) || (a_item_r.op == msr_pkg::OP_STOP);
    m_sel     = multi ? msr_pkg::MOTOR_W'(idx_r) : a_item_r.motor;
    m_idx     = m_sel[msr_pkg::MIDX_W-1:0];
    motor_ok  = {1'b0, m_sel} < (msr_pkg::MOTOR_W+1)'(msr_pkg::NUM_MOTORS);
    // motors without a mask bit are never inverted
    inv       = ({1'b0, m_sel} < (msr_pkg::MOTOR_W+1)'(msr_pkg::INV_W)) &&
                cfg.invert_mask[m_sel[0]];
    last_step = !multi || (idx_r == msr_pkg::MIDX_W'(msr_pkg::NUM_MOTORS - 1));
    go        = a_valid_r && step_ready;

    cur_sel = cur_r[m_idx];
    tgt_sel = tgt_r[m_idx];
    cur18   = 18'(cur_sel);
    tgt18   = 18'(tgt_sel);
    diff    = tgt18 - cur18;
    step18  = 18'({3'b000, cfg.ramp_step});
    lim18   = 18'({3'b000, cfg.max_speed});

    if (diff > step18) begin
      ramp = cur18 + step18;
    end else if (diff < -step18) begin
      ramp = cur18 - step18;
    end else begin
      ramp = tgt18;
    end
    if (ramp > lim18) begin
      ramp = lim18;
    end
    if (ramp < -lim18) begin
      ramp = -lim18;
    end
    cur_new = ramp[15:0];

    // most negative command saturates to -full
    cmd_sat = (a_item_r.speed_cmd == 16'sh8000) ? -16'sd32767 : a_item_r.speed_cmd;

    if (a_item_r.op == msr_pkg::OP_TICK) begin
      spd_user = inv ? -cur_new : cur_new;
    end else if (a_item_r.op == msr_pkg::OP_READ && motor_ok) begin
      spd_user = inv ? -cur_sel : cur_sel;
    end else begin
      spd_user = '0;
    end

    step.motor_index = m_sel;
    step.op          = a_item_r.op;
    step.pos         = cur_new > 16'sd0;
    step.neg         = cur_new < 16'sd0;
    step.mag         = cur_new[15] ? 15'(-cur_new) : cur_new[14:0];
    step.speed_now   = spd_user;
    step.status      = !multi && !motor_ok;
    step.last        = last_step;
  end

  assign step_valid = a_valid_r;
  assign in_ready   = !a_valid_r || (go && last_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      idx_r     <= '0;
    end else if (in_valid && in_ready) begin
      a_valid_r <= 1'b1;
      idx_r     <= '0;
    end else if (go && last_step) begin
      a_valid_r <= 1'b0;
    end else if (go) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msr_pkg::NUM_MOTORS; i++) begin
        tgt_r[i] <= '0;
        cur_r[i] <= '0;
      end
    end else if (go) begin
      unique case (a_item_r.op)
        msr_pkg::OP_SET: begin
          if (motor_ok) begin
            tgt_r[m_idx] <= inv ? -cmd_sat : cmd_sat;
          end
        end
        msr_pkg::OP_TICK: begin
          cur_r[m_idx] <= cur_new;
        end
        msr_pkg::OP_STOP: begin
          for (int i = 0; i < msr_pkg::NUM_MOTORS; i++) begin
            tgt_r[i] <= '0;
            cur_r[i] <= '0;
          end
        end
        msr_pkg::OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/msr_duty.sv =====
// ----------------------------------------------------------------------------
// msr_duty
// Duty pipeline: step register, magnitude times full scale, divide by full
// Q1.15 scale and side selection into the output register.
// ----------------------------------------------------------------------------
module msr_duty (
  input  logic           clk,
  input  logic           rst_n,
  input  msr_pkg::cfg_t  cfg,
  input  logic           step_valid,
  output logic           step_ready,
  input  msr_pkg::step_t step,
  output logic           out_valid,
  input  logic           out_ready,
  output msr_pkg::out_t  out_data
);

  logic           s_valid_r;
  msr_pkg::step_t s_r;
  logic           p_valid_r;
  msr_pkg::prod_t p_r;
  msr_pkg::prod_t p_nxt;
  logic           o_valid_r;
  msr_pkg::out_t  o_r;
  msr_pkg::out_t  o_nxt;

  logic           o_free;
  logic           p_free;
  logic [15:0]    q1;
  logic [16:0]    r1;
  logic [16:0]    q;
  logic [15:0]    d;

  assign o_free     = !o_valid_r || out_ready;
  assign p_free     = !p_valid_r || o_free;
  assign step_ready = !s_valid_r || p_free;

  always_comb begin
    p_nxt.motor_index = s_r.motor_index;
    p_nxt.op          = s_r.op;
    p_nxt.pos         = s_r.pos;
    p_nxt.neg         = s_r.neg;
    p_nxt.prod        = msr_pkg::PROD_W'(s_r.mag) * msr_pkg::PROD_W'(cfg.duty_full_scale);
    p_nxt.speed_now   = s_r.speed_now;
    p_nxt.status      = s_r.status;
    p_nxt.last        = s_r.last;
  end

  // x / 32767: x>>15 leaves a remainder below three times the divisor
  always_comb begin
    q1 = p_r.prod[msr_pkg::PROD_W-1:15];
    r1 = 17'(p_r.prod[14:0]) + 17'(q1);
    q  = 17'(q1) + 17'(r1 >= 17'(msr_pkg::FULL_Q)) + 17'(r1 >= 17'(2 * msr_pkg::FULL_Q));
    d  = q[15:0];

    o_nxt.motor_index = p_r.motor_index;
    o_nxt.speed_now   = p_r.speed_now;
    o_nxt.status      = p_r.status;
    o_nxt.last        = p_r.last;
    o_nxt.fwd_duty    = '0;
    o_nxt.rev_duty    = '0;
    if (p_r.op == msr_pkg::OP_TICK) begin
      priority if (p_r.pos) begin
        o_nxt.fwd_duty = d;
      end else if (p_r.neg) begin
        o_nxt.rev_duty = d;
      end else if (cfg.brake_mode) begin
        o_nxt.fwd_duty = cfg.duty_full_scale;
        o_nxt.rev_duty = cfg.duty_full_scale;
      end else begin
        o_nxt.fwd_duty = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (step_ready) begin
        s_valid_r <= step_valid;
      end
      if (p_free) begin
        p_valid_r <= s_valid_r;
      end
      if (o_free) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_valid && step_ready) begin
      s_r <= step;
    end
    if (s_valid_r && p_free) begin
      p_r <= p_nxt;
    end
    if (p_valid_r && o_free) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_r;

endmodule

// ===== rtl/motor_speed_ramp_hbridge_drive.sv =====
// ----------------------------------------------------------------------------
// motor_speed_ramp_hbridge_drive
// Two-motor speed ramp with h-bridge forward/reverse duty generation.
// ----------------------------------------------------------------------------
// path: an accepted item sits in the issue register, then the step, product and
//   output registers; results leave one per cycle while out_ready does not stall
// steps: one per set or read; tick and stop get one per motor (NUM_MOTORS) in turn
// reset: synchronous; speeds cleared, registers to defaults, pipeline emptied
module motor_speed_ramp_hbridge_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  msr_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output msr_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [msr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  msr_pkg::cfg_t  cfg_r;
  msr_pkg::cfg_t  cfg_nxt;
  logic           step_valid;
  logic           step_ready;
  msr_pkg::step_t step;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        msr_pkg::CFG_RAMP_STEP:  cfg_nxt.ramp_step       = cfg_wdata[14:0];
        msr_pkg::CFG_MAX_SPEED:  cfg_nxt.max_speed       = cfg_wdata[14:0];
        msr_pkg::CFG_DUTY_FULL:  cfg_nxt.duty_full_scale = cfg_wdata;
        msr_pkg::CFG_BRAKE_MODE: cfg_nxt.brake_mode      = cfg_wdata[0];
        msr_pkg::CFG_INVERT:     cfg_nxt.invert_mask     = cfg_wdata[msr_pkg::INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_step       <= 15'd655;
      cfg_r.max_speed       <= 15'd32767;
      cfg_r.duty_full_scale <= 16'd1023;
      cfg_r.brake_mode      <= 1'b0;
      cfg_r.invert_mask     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msr_issue u_issue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step       (step)
  );

  msr_duty u_duty (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step       (step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/msr_checker.sv =====
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module msr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input msr_pkg::out_t out_data
);

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an error result is single, carries a bad index and no speed
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.last && out_data.speed_now == 16'sd0 &&
      {1'b0, out_data.motor_index} >= (msr_pkg::MOTOR_W+1)'(msr_pkg::NUM_MOTORS))
    else $error("bad error result");

  // both sides driven only as the equal brake level
  a_sides: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fwd_duty != 16'd0 && out_data.rev_duty != 16'd0 |->
      out_data.fwd_duty == out_data.rev_duty)
    else $error("both bridge sides driven unequally");

endmodule

bind motor_speed_ramp_hbridge_drive msr_checker u_msr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
